// ----- src/pld_pkg.sv -----
// Shared widths, control struct and helper functions for the point-to-line
// distance pipeline. No dependencies; imported by every module of the block.
package pld_pkg;

	localparam int CW       = 48;
	localparam int DW       = CW + 1;
	localparam int PW       = 2 * DW;
	localparam int XW       = PW + 1;
	localparam int LW       = PW + 2;
	localparam int NL       = 4;
	localparam int LB       = (XW - 1 + NL - 1) / NL;
	localparam int MW       = LB * NL;
	localparam int ROWW     = LB * (NL + 1);
	localparam int CSW      = 2 * MW;
	localparam int DSTW     = CW - 1;
	localparam int QW       = 2 * DSTW;
	localparam int TW       = CSW - QW;
	localparam int RW       = DSTW + 2;
	localparam int MUL_LAT  = 3;
	localparam int PIPE_LAT = 1 + MUL_LAT + 1 + MUL_LAT + 1 + (QW + 1) + DSTW + 1;

	typedef struct packed {
		logic valid;
		logic degen;
		logic sat;
	} pld_ctl_t;

	function automatic logic [MW-1:0] abs_d(input logic signed [DW-1:0] x);
		logic [DW-1:0] m;
		m = x[DW-1] ? $unsigned(-x) : $unsigned(x);
		return MW'(m);
	endfunction

	function automatic logic [MW-1:0] abs_x(input logic signed [XW-1:0] x);
		logic [XW-1:0] m;
		m = x[XW-1] ? $unsigned(-x) : $unsigned(x);
		return MW'(m);
	endfunction

	function automatic logic signed [XW-1:0] apply_sign(input logic neg,
			input logic [CSW-1:0] p);
		logic signed [XW-1:0] m;
		m = $signed({1'b0, p[XW-2:0]});
		return neg ? -m : m;
	endfunction

endpackage

// ----- src/point_line_distance_3d_unit.sv -----
// Top level: perpendicular distance from a 3-D point to a line, fully pipelined.
// Depends on pld_pkg, pld_mul, pld_div, pld_sqrt.
//
//  channel   handshake          payload
//  request   start / busy       point_*, source_*, blocker_* (48-bit signed)
//  result    done (strobe)      distance (47-bit), degenerate
//
// One request per cycle; busy stays low. Requests pass the 95-stage divider and
// the 47-stage square root. Reset clears only the valid bits and the divider and
// root ctl structs. The result side cannot stall, so nothing in the pipe waits.
module point_line_distance_3d_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [pld_pkg::CW-1:0]   point_x,
	input  logic signed [pld_pkg::CW-1:0]   point_y,
	input  logic signed [pld_pkg::CW-1:0]   point_z,
	input  logic signed [pld_pkg::CW-1:0]   source_x,
	input  logic signed [pld_pkg::CW-1:0]   source_y,
	input  logic signed [pld_pkg::CW-1:0]   source_z,
	input  logic signed [pld_pkg::CW-1:0]   blocker_x,
	input  logic signed [pld_pkg::CW-1:0]   blocker_y,
	input  logic signed [pld_pkg::CW-1:0]   blocker_z,
	output logic                            done,
	output logic [pld_pkg::DSTW-1:0]        distance,
	output logic                            degenerate
);
	import pld_pkg::*;

	logic                 acc;
	logic                 valid_s1;
	logic                 degen_s1;
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] v_s1 [3];

	logic [MW-1:0]        m1_a [9];
	logic [MW-1:0]        m1_b [9];
	logic [CSW-1:0]       m1_p [9];
	logic [5:0]           m1_neg;
	logic [MUL_LAT-1:0]   m1_vld_s;
	logic [MUL_LAT-1:0]   m1_dgn_s;
	logic [5:0]           m1_neg_s [MUL_LAT];

	logic                 valid_s2;
	logic                 degen_s2;
	logic [LW-1:0]        lsq_s2;
	logic signed [XW-1:0] cr_s2 [3];

	logic [MW-1:0]        m2_a [3];
	logic [CSW-1:0]       m2_p [3];
	logic [MUL_LAT-1:0]   m2_vld_s;
	logic [MUL_LAT-1:0]   m2_dgn_s;
	logic [LW-1:0]        m2_lsq_s [MUL_LAT];

	logic                 valid_s3;
	logic                 degen_s3;
	logic [LW-1:0]        lsq_s3;
	logic [CSW-1:0]       csq_s3;

	pld_ctl_t             div_in;
	pld_ctl_t             div_out;
	logic [QW-1:0]        quo;
	pld_ctl_t             sq_out;
	logic [DSTW-1:0]      root;

	logic                 done_q;
	logic                 dgn_q;
	logic [DSTW-1:0]      dist_q;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	// front: differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		d_s1[0]  <= DW'(blocker_x) - DW'(source_x);
		d_s1[1]  <= DW'(blocker_y) - DW'(source_y);
		d_s1[2]  <= DW'(blocker_z) - DW'(source_z);
		v_s1[0]  <= DW'(point_x) - DW'(blocker_x);
		v_s1[1]  <= DW'(point_y) - DW'(blocker_y);
		v_s1[2]  <= DW'(point_z) - DW'(blocker_z);
		degen_s1 <= (source_x == blocker_x) && (source_y == blocker_y) &&
			(source_z == blocker_z);
	end

	// squares of D, then the six cross-product terms as sign and magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m1_a[i] = abs_d(d_s1[i]);
			m1_b[i] = abs_d(d_s1[i]);
		end
		m1_a[3] = abs_d(v_s1[1]);  m1_b[3] = abs_d(d_s1[2]);
		m1_a[4] = abs_d(v_s1[2]);  m1_b[4] = abs_d(d_s1[1]);
		m1_a[5] = abs_d(v_s1[2]);  m1_b[5] = abs_d(d_s1[0]);
		m1_a[6] = abs_d(v_s1[0]);  m1_b[6] = abs_d(d_s1[2]);
		m1_a[7] = abs_d(v_s1[0]);  m1_b[7] = abs_d(d_s1[1]);
		m1_a[8] = abs_d(v_s1[1]);  m1_b[8] = abs_d(d_s1[0]);
		m1_neg[0] = v_s1[1][DW-1] ^ d_s1[2][DW-1];
		m1_neg[1] = v_s1[2][DW-1] ^ d_s1[1][DW-1];
		m1_neg[2] = v_s1[2][DW-1] ^ d_s1[0][DW-1];
		m1_neg[3] = v_s1[0][DW-1] ^ d_s1[2][DW-1];
		m1_neg[4] = v_s1[0][DW-1] ^ d_s1[1][DW-1];
		m1_neg[5] = v_s1[1][DW-1] ^ d_s1[0][DW-1];
	end

	for (genvar g = 0; g < 9; g++) begin : g_mul1
		pld_mul u_mul (.clk(clk), .a(m1_a[g]), .b(m1_b[g]), .p(m1_p[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_vld_s <= '0;
		end else begin
			m1_vld_s <= {m1_vld_s[MUL_LAT-2:0], valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		m1_dgn_s    <= {m1_dgn_s[MUL_LAT-2:0], degen_s1};
		m1_neg_s[0] <= m1_neg;
		for (int k = 1; k < MUL_LAT; k++) begin
			m1_neg_s[k] <= m1_neg_s[k-1];
		end
	end

	// |D|^2 and the cross product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= m1_vld_s[MUL_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		degen_s2 <= m1_dgn_s[MUL_LAT-1];
		lsq_s2   <= LW'(m1_p[0]) + LW'(m1_p[1]) + LW'(m1_p[2]);
		cr_s2[0] <= apply_sign(m1_neg_s[MUL_LAT-1][0], m1_p[3]) -
			apply_sign(m1_neg_s[MUL_LAT-1][1], m1_p[4]);
		cr_s2[1] <= apply_sign(m1_neg_s[MUL_LAT-1][2], m1_p[5]) -
			apply_sign(m1_neg_s[MUL_LAT-1][3], m1_p[6]);
		cr_s2[2] <= apply_sign(m1_neg_s[MUL_LAT-1][4], m1_p[7]) -
			apply_sign(m1_neg_s[MUL_LAT-1][5], m1_p[8]);
	end

	for (genvar g = 0; g < 3; g++) begin : g_mul2
		assign m2_a[g] = abs_x(cr_s2[g]);
		pld_mul u_mul (.clk(clk), .a(m2_a[g]), .b(m2_a[g]), .p(m2_p[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m2_vld_s <= '0;
		end else begin
			m2_vld_s <= {m2_vld_s[MUL_LAT-2:0], valid_s2};
		end
	end

	always_ff @(posedge clk) begin
		m2_dgn_s    <= {m2_dgn_s[MUL_LAT-2:0], degen_s2};
		m2_lsq_s[0] <= lsq_s2;
		for (int k = 1; k < MUL_LAT; k++) begin
			m2_lsq_s[k] <= m2_lsq_s[k-1];
		end
	end

	// |cross|^2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= m2_vld_s[MUL_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		degen_s3 <= m2_dgn_s[MUL_LAT-1];
		lsq_s3   <= m2_lsq_s[MUL_LAT-1];
		csq_s3   <= m2_p[0] + m2_p[1] + m2_p[2];
	end

	assign div_in = '{valid: valid_s3, degen: degen_s3, sat: 1'b0};

	pld_div u_div (
		.clk(clk), .arst_n(arst_n), .in_ctl(div_in), .num(csq_s3), .den(lsq_s3),
		.out_ctl(div_out), .quo(quo)
	);

	pld_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_ctl(div_out), .rad(quo),
		.out_ctl(sq_out), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sq_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		dgn_q <= sq_out.degen;
		if (sq_out.degen) begin
			dist_q <= '0;
		end else if (sq_out.sat) begin
			dist_q <= '1;
		end else begin
			dist_q <= root;
		end
	end

	assign done       = done_q;
	assign distance   = dist_q;
	assign degenerate = dgn_q;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##PIPE_LAT done)
		else $error("request did not complete after pipeline latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, PIPE_LAT))
		else $error("result without matching request");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> distance == '0)
		else $error("degenerate line with nonzero distance");
`endif

endmodule

// ----- src/pld_mul.sv -----
// Unsigned MW x MW multiplier split into NL x NL limb products, three stages.
// Depends on pld_pkg.
module pld_mul (
	input  logic                    clk,
	input  logic [pld_pkg::MW-1:0]  a,
	input  logic [pld_pkg::MW-1:0]  b,
	output logic [pld_pkg::CSW-1:0] p
);
	import pld_pkg::*;

	logic [2*LB-1:0] pp_s1 [NL][NL];
	logic [ROWW-1:0] row_c [NL];
	logic [ROWW-1:0] row_s2 [NL];
	logic [CSW-1:0]  prod_c;
	logic [CSW-1:0]  prod_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			for (int j = 0; j < NL; j++) begin
				pp_s1[i][j] <= (2*LB)'(a[i*LB +: LB]) * (2*LB)'(b[j*LB +: LB]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NL; j++) begin
				row_c[i] = row_c[i] + (ROWW'(pp_s1[i][j]) << (LB * j));
			end
		end
	end

	always_ff @(posedge clk) begin
		row_s2 <= row_c;
	end

	always_comb begin
		prod_c = '0;
		for (int i = 0; i < NL; i++) begin
			prod_c = prod_c + (CSW'(row_s2[i]) << (LB * i));
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= prod_c;
	end

	assign p = prod_s3;

endmodule

// ----- src/pld_div.sv -----
// Restoring divider, one quotient bit per stage, with overflow detect in front.
// Depends on pld_pkg.
module pld_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pld_pkg::pld_ctl_t       in_ctl,
	input  logic [pld_pkg::CSW-1:0] num,
	input  logic [pld_pkg::LW-1:0]  den,
	output pld_pkg::pld_ctl_t       out_ctl,
	output logic [pld_pkg::QW-1:0]  quo
);
	import pld_pkg::*;

	pld_ctl_t       ctl_s [QW+1];
	logic [LW-1:0]  rem_s [QW+1];
	logic [QW-1:0]  lo_s  [QW+1];
	logic [LW-1:0]  den_s [QW+1];
	logic [QW-1:0]  quo_s [QW+1];
	logic           top_ge;

	assign top_ge = num[CSW-1:QW] >= TW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0] <= '{valid: in_ctl.valid, degen: in_ctl.degen, sat: top_ge};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num[QW +: LW];
		lo_s[0]  <= num[QW-1:0];
		den_s[0] <= den;
		quo_s[0] <= '0;
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [LW:0] t;
		logic [LW:0] diff;
		logic        ge;

		assign t    = {rem_s[k-1], lo_s[k-1][QW-k]};
		assign ge   = t >= {1'b0, den_s[k-1]};
		assign diff = t - {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[LW-1:0] : t[LW-1:0];
			lo_s[k]  <= lo_s[k-1];
			den_s[k] <= den_s[k-1];
			quo_s[k] <= quo_s[k-1] | (QW'(ge) << (QW-k));
		end
	end

	assign out_ctl = ctl_s[QW];
	assign quo     = quo_s[QW];

endmodule

// ----- src/pld_sqrt.sv -----
// Integer square root, one root bit per stage (restoring, two radicand bits).
// Depends on pld_pkg.
module pld_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pld_pkg::pld_ctl_t        in_ctl,
	input  logic [pld_pkg::QW-1:0]   rad,
	output pld_pkg::pld_ctl_t        out_ctl,
	output logic [pld_pkg::DSTW-1:0] root
);
	import pld_pkg::*;

	pld_ctl_t        ctl_s  [DSTW];
	logic [RW-1:0]   rem_s  [DSTW];
	logic [DSTW-1:0] root_s [DSTW];
	logic [QW-1:0]   rad_s  [DSTW];

	for (genvar k = 0; k < DSTW; k++) begin : g_stage
		pld_ctl_t        ctl_p;
		logic [RW-1:0]   rem_p;
		logic [DSTW-1:0] root_p;
		logic [QW-1:0]   rad_p;
		logic [RW+1:0]   t;
		logic [RW+1:0]   trial;
		logic [RW+1:0]   diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign ctl_p  = in_ctl;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
		end else begin : g_next
			assign ctl_p  = ctl_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
		end

		assign t     = {rem_p, rad_p[2*(DSTW-1-k) +: 2]};
		assign trial = (RW+2)'({root_p, 2'b01});
		assign ge    = t >= trial;
		assign diff  = t - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? diff[RW-1:0] : t[RW-1:0];
			root_s[k] <= {root_p[DSTW-2:0], ge};
			rad_s[k]  <= rad_p;
		end
	end

	assign out_ctl = ctl_s[DSTW-1];
	assign root    = root_s[DSTW-1];

endmodule
